// File: rtl/utrq_pkg.sv
// Shared constants and types for the UART transmit/receive queue server.
package utrq_pkg;
    localparam int TX_DEPTH   = 4096;
    localparam int RX_DEPTH   = 4096;
    localparam int WAIT_DEPTH = 32;
    localparam int TX_AW   = $clog2(TX_DEPTH);
    localparam int RX_AW   = $clog2(RX_DEPTH);
    localparam int WAIT_AW = $clog2(WAIT_DEPTH);

    localparam logic [1:0] OP_TX_READY = 2'd0;
    localparam logic [1:0] OP_RX_BYTE  = 2'd1;
    localparam logic [1:0] OP_GET      = 2'd2;
    localparam logic [1:0] OP_PUT      = 2'd3;

    localparam logic [1:0] RK_NONE   = 2'd0;
    localparam logic [1:0] RK_BYTE   = 2'd1;
    localparam logic [1:0] RK_ACK    = 2'd2;
    localparam logic [1:0] RK_REJECT = 2'd3;

    localparam logic CFG_LOCK_START = 1'b0;
    localparam logic CFG_LOCK_END   = 1'b1;

    localparam logic [7:0] LOCK_START_RESET = 8'd19;
    localparam logic [7:0] LOCK_END_RESET   = 8'd20;

    typedef struct packed {
        logic       tx_valid;
        logic [7:0] tx_byte;
        logic [1:0] reply_kind;
        logic [7:0] reply_task;
        logic [7:0] reply_byte;
        logic       dropped;
        logic       last;
    } result_t;
endpackage

// File: rtl/uart_tx_rx_queue_server_top.sv
// Top level: event sequencer around the four queue memories.
//
// An item is taken when start is high and busy is low. Transmitter-ready,
// receive, get and put items pass through accept, memory read and result
// steps; a lock-end put then walks the held-writer queue up to and including
// the first held lock-start put, each held entry with a read step then a
// result step, and ends with a final acknowledgment. Each result appears for
// one cycle on result_valid with last marking the final one; the receiver
// cannot stall. Configuration writes are always accepted (cfg_ready is tied high).
module uart_tx_rx_queue_server_top (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    output logic       busy,
    input  logic [1:0] operation,
    input  logic [7:0] data_byte,
    input  logic [7:0] task_id,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic       cfg_index,
    input  logic [7:0] cfg_data,
    output logic       result_valid,
    output logic       tx_valid,
    output logic [7:0] tx_byte,
    output logic [1:0] reply_kind,
    output logic [7:0] reply_task,
    output logic [7:0] reply_byte,
    output logic       dropped,
    output logic       last
);
    localparam int TAW = utrq_pkg::TX_AW;
    localparam int RAW = utrq_pkg::RX_AW;
    localparam int WAW = utrq_pkg::WAIT_AW;

    typedef enum logic [2:0] {S_IDLE, S_READ, S_EXEC, S_DRAIN_RD, S_DRAIN_EX,
                              S_FINAL} state_t;

    state_t            state_reg;
    logic [1:0]        op_reg;
    logic [7:0]        data_reg, task_reg;
    logic [7:0]        lock_start_reg, lock_end_reg;
    logic [TAW-1:0]    tx_head_reg, tx_tail_reg;
    logic [TAW:0]      tx_count_reg;
    logic [RAW-1:0]    rx_head_reg, rx_tail_reg;
    logic [RAW:0]      rx_count_reg;
    logic [WAW-1:0]    rd_head_reg, rd_tail_reg;
    logic [WAW:0]      rd_count_reg;
    logic [WAW-1:0]    hd_head_reg, hd_tail_reg;
    logic [WAW:0]      hd_count_reg;
    logic              line_idle_reg;
    logic [7:0]        owner_reg;
    utrq_pkg::result_t res_reg;
    logic              res_valid_reg;

    logic       tx_we, rx_we, rd_we, hd_we;
    logic [7:0] tx_q, rx_q, rd_q;
    logic [15:0] hd_q;
    logic       held_put, plain_put, tx_push;

    assign cfg_ready = 1'b1;
    assign busy = (state_reg != S_IDLE);

    assign held_put = (owner_reg != 8'd0) && (owner_reg != task_reg);

    // byte pushed into tx FIFO by a plain put or a drain step, unless the line is idle or the FIFO is full
    assign plain_put = (state_reg == S_EXEC) && (op_reg == utrq_pkg::OP_PUT) && !held_put
                       && (data_reg != lock_start_reg) && (data_reg != lock_end_reg);
    assign tx_push = (plain_put
                      || (state_reg == S_DRAIN_EX && hd_q[15:8] != lock_start_reg))
                     && !line_idle_reg
                     && (tx_count_reg < (TAW+1)'(utrq_pkg::TX_DEPTH));

    assign tx_we = 1'b0 | ((state_reg == S_EXEC || state_reg == S_DRAIN_EX) && tx_push);
    assign rx_we = (state_reg == S_EXEC) && (op_reg == utrq_pkg::OP_RX_BYTE)
                   && !(rd_count_reg != '0 && rx_count_reg == '0)
                   && (rx_count_reg < (RAW+1)'(utrq_pkg::RX_DEPTH));
    assign rd_we = (state_reg == S_EXEC) && (op_reg == utrq_pkg::OP_GET)
                   && (rx_count_reg == '0)
                   && (rd_count_reg < (WAW+1)'(utrq_pkg::WAIT_DEPTH));
    assign hd_we = (state_reg == S_EXEC) && (op_reg == utrq_pkg::OP_PUT) && held_put
                   && (hd_count_reg < (WAW+1)'(utrq_pkg::WAIT_DEPTH));

    logic [7:0] tx_wdata;
    assign tx_wdata = (state_reg == S_DRAIN_EX) ? hd_q[15:8] : data_reg;

    utrq_ram #(.WIDTH(8), .DEPTH(utrq_pkg::TX_DEPTH)) u_tx_ram (
        .clk(clk), .we(tx_we), .waddr(tx_tail_reg), .wdata(tx_wdata),
        .raddr(tx_head_reg), .rdata(tx_q));
    utrq_ram #(.WIDTH(8), .DEPTH(utrq_pkg::RX_DEPTH)) u_rx_ram (
        .clk(clk), .we(rx_we), .waddr(rx_tail_reg), .wdata(data_reg),
        .raddr(rx_head_reg), .rdata(rx_q));
    utrq_ram #(.WIDTH(8), .DEPTH(utrq_pkg::WAIT_DEPTH)) u_rd_ram (
        .clk(clk), .we(rd_we), .waddr(rd_tail_reg), .wdata(task_reg),
        .raddr(rd_head_reg), .rdata(rd_q));
    utrq_ram #(.WIDTH(16), .DEPTH(utrq_pkg::WAIT_DEPTH)) u_hd_ram (
        .clk(clk), .we(hd_we), .waddr(hd_tail_reg), .wdata({data_reg, task_reg}),
        .raddr(hd_head_reg), .rdata(hd_q));

    function automatic logic [TAW-1:0] tadv(input logic [TAW-1:0] i);
        tadv = (32'(i) + 1 >= utrq_pkg::TX_DEPTH) ? '0 : i + 1'b1;
    endfunction
    function automatic logic [RAW-1:0] radv(input logic [RAW-1:0] i);
        radv = (32'(i) + 1 >= utrq_pkg::RX_DEPTH) ? '0 : i + 1'b1;
    endfunction
    function automatic logic [WAW-1:0] wadv(input logic [WAW-1:0] i);
        wadv = (32'(i) + 1 >= utrq_pkg::WAIT_DEPTH) ? '0 : i + 1'b1;
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            lock_start_reg <= utrq_pkg::LOCK_START_RESET;
            lock_end_reg   <= utrq_pkg::LOCK_END_RESET;
            tx_head_reg <= '0; tx_tail_reg <= '0; tx_count_reg <= '0;
            rx_head_reg <= '0; rx_tail_reg <= '0; rx_count_reg <= '0;
            rd_head_reg <= '0; rd_tail_reg <= '0; rd_count_reg <= '0;
            hd_head_reg <= '0; hd_tail_reg <= '0; hd_count_reg <= '0;
            line_idle_reg <= 1'b0;
            owner_reg     <= 8'd0;
            res_valid_reg <= 1'b0;
            res_reg       <= '0;
            op_reg <= '0; data_reg <= '0; task_reg <= '0;
        end
        else
        begin
            res_valid_reg <= 1'b0;
            res_reg       <= '0;
            if (cfg_valid)
            begin
                case (cfg_index)
                    utrq_pkg::CFG_LOCK_START: lock_start_reg <= cfg_data;
                    utrq_pkg::CFG_LOCK_END:   lock_end_reg   <= cfg_data;
                    default: ;
                endcase
            end
            if (tx_we)
            begin
                tx_tail_reg  <= tadv(tx_tail_reg);
                tx_count_reg <= tx_count_reg + 1'b1;
            end
            if (rx_we)
            begin
                rx_tail_reg  <= radv(rx_tail_reg);
                rx_count_reg <= rx_count_reg + 1'b1;
            end
            if (rd_we)
            begin
                rd_tail_reg  <= wadv(rd_tail_reg);
                rd_count_reg <= rd_count_reg + 1'b1;
            end
            if (hd_we)
            begin
                hd_tail_reg  <= wadv(hd_tail_reg);
                hd_count_reg <= hd_count_reg + 1'b1;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        op_reg <= operation; data_reg <= data_byte; task_reg <= task_id;
                        state_reg <= S_READ;
                    end
                end
                S_READ:
                    state_reg <= S_EXEC;
                S_EXEC:
                begin
                    state_reg <= S_IDLE;
                    res_valid_reg <= 1'b1;
                    res_reg.last  <= 1'b1;
                    case (op_reg)
                        utrq_pkg::OP_TX_READY:
                        begin
                            if (tx_count_reg != '0)
                            begin
                                tx_head_reg  <= tadv(tx_head_reg);
                                tx_count_reg <= tx_count_reg - 1'b1;
                                line_idle_reg <= 1'b0;
                                res_reg.tx_valid <= 1'b1;
                                res_reg.tx_byte  <= tx_q;
                            end
                            else
                            begin
                                line_idle_reg <= 1'b1;
                            end
                        end
                        utrq_pkg::OP_RX_BYTE:
                        begin
                            if (rd_count_reg != '0 && rx_count_reg == '0)
                            begin
                                rd_head_reg  <= wadv(rd_head_reg);
                                rd_count_reg <= rd_count_reg - 1'b1;
                                res_reg.reply_kind <= utrq_pkg::RK_BYTE;
                                res_reg.reply_task <= rd_q;
                                res_reg.reply_byte <= data_reg;
                            end
                            else if (!rx_we)
                            begin
                                res_reg.dropped <= 1'b1;
                            end
                        end
                        utrq_pkg::OP_GET:
                        begin
                            if (rx_count_reg != '0)
                            begin
                                rx_head_reg  <= radv(rx_head_reg);
                                rx_count_reg <= rx_count_reg - 1'b1;
                                res_reg.reply_kind <= utrq_pkg::RK_BYTE;
                                res_reg.reply_task <= task_reg;
                                res_reg.reply_byte <= rx_q;
                            end
                            else if (!rd_we)
                            begin
                                res_reg.reply_kind <= utrq_pkg::RK_REJECT;
                                res_reg.reply_task <= task_reg;
                            end
                        end
                        default:
                        begin
                            if (held_put)
                            begin
                                if (!hd_we)
                                begin
                                    res_reg.reply_kind <= utrq_pkg::RK_REJECT;
                                    res_reg.reply_task <= task_reg;
                                    res_reg.dropped    <= 1'b1;
                                end
                            end
                            else if (data_reg == lock_start_reg)
                            begin
                                owner_reg <= task_reg;
                                res_reg.reply_kind <= utrq_pkg::RK_ACK;
                                res_reg.reply_task <= task_reg;
                            end
                            else if (data_reg == lock_end_reg)
                            begin
                                res_valid_reg <= 1'b0;
                                res_reg.last  <= 1'b0;
                                state_reg <= (hd_count_reg != '0) ? S_DRAIN_RD : S_FINAL;
                                if (hd_count_reg == '0)
                                begin
                                    owner_reg <= 8'd0;
                                end
                            end
                            else
                            begin
                                res_reg.reply_kind <= utrq_pkg::RK_ACK;
                                res_reg.reply_task <= task_reg;
                                if (line_idle_reg)
                                begin
                                    line_idle_reg <= 1'b0;
                                    res_reg.tx_valid <= 1'b1;
                                    res_reg.tx_byte  <= data_reg;
                                end
                                else if (!tx_we)
                                begin
                                    res_reg.dropped <= 1'b1;
                                end
                            end
                        end
                    endcase
                end
                S_DRAIN_RD:
                    state_reg <= S_DRAIN_EX;
                S_DRAIN_EX:
                begin
                    res_valid_reg <= 1'b1;
                    res_reg.reply_kind <= utrq_pkg::RK_ACK;
                    res_reg.reply_task <= hd_q[7:0];
                    hd_head_reg  <= wadv(hd_head_reg);
                    hd_count_reg <= hd_count_reg - 1'b1;
                    if (hd_q[15:8] == lock_start_reg)
                    begin
                        owner_reg <= hd_q[7:0];
                        state_reg <= S_FINAL;
                    end
                    else
                    begin
                        if (line_idle_reg)
                        begin
                            line_idle_reg <= 1'b0;
                            res_reg.tx_valid <= 1'b1;
                            res_reg.tx_byte  <= hd_q[15:8];
                        end
                        else if (!tx_we)
                        begin
                            res_reg.dropped <= 1'b1;
                        end
                        if (hd_count_reg == (WAW+1)'(1))
                        begin
                            owner_reg <= 8'd0;
                            state_reg <= S_FINAL;
                        end
                        else
                        begin
                            state_reg <= S_DRAIN_RD;
                        end
                    end
                end
                S_FINAL:
                begin
                    res_valid_reg <= 1'b1;
                    res_reg.reply_kind <= utrq_pkg::RK_ACK;
                    res_reg.reply_task <= task_reg;
                    res_reg.last <= 1'b1;
                    state_reg <= S_IDLE;
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

    assign result_valid = res_valid_reg;
    assign tx_valid   = res_reg.tx_valid;
    assign tx_byte    = res_reg.tx_byte;
    assign reply_kind = res_reg.reply_kind;
    assign reply_task = res_reg.reply_task;
    assign reply_byte = res_reg.reply_byte;
    assign dropped    = res_reg.dropped;
    assign last       = res_reg.last;

    a_tx_count: assert property (@(posedge clk) disable iff (!rst_n)
        tx_count_reg <= (TAW+1)'(utrq_pkg::TX_DEPTH))
        else $error("tx count overflow");
    a_hd_count: assert property (@(posedge clk) disable iff (!rst_n)
        hd_count_reg <= (WAW+1)'(utrq_pkg::WAIT_DEPTH))
        else $error("held count overflow");
    a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && res_reg.last) |-> state_reg == S_IDLE)
        else $error("last result while still working");
    a_drain_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_DRAIN_RD |-> hd_count_reg != '0)
        else $error("drain on empty held queue");
endmodule

// File: rtl/utrq_ram.sv
// Generic single-port-write, single-read synchronous RAM with registered read.
module utrq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
